// ===== rtl/bmm_pkg.sv =====
package bmm_pkg;

	// Access kinds carried by the action field.
	typedef enum logic [1:0] {
		ACT_READ      = 2'd0,
		ACT_WRITE     = 2'd1,
		ACT_BANK_WR   = 2'd2,
		ACT_REMAP_WR  = 2'd3
	} action_t;

	// Memories that an access can land in.
	typedef enum logic [2:0] {
		TGT_NONE    = 3'd0,
		TGT_OVERLAY = 3'd1,
		TGT_BOOT    = 3'd2,
		TGT_CART    = 3'd3,
		TGT_VRAM    = 3'd4,
		TGT_CHRAM   = 3'd5,
		TGT_MAIN    = 3'd6
	} target_t;

	localparam int  WIN_BITS  = 14;
	localparam int  PAGE_BITS = 6;

	localparam logic [PAGE_BITS-1:0] PAGE_BOOT  = 6'd0;
	localparam logic [PAGE_BITS-1:0] PAGE_CART  = 6'd19;
	localparam logic [PAGE_BITS-1:0] PAGE_VRAM  = 6'd20;
	localparam logic [PAGE_BITS-1:0] PAGE_CHRAM = 6'd21;

	localparam logic [WIN_BITS-1:0] OVL_LO     = 14'h3000;
	localparam logic [WIN_BITS-1:0] OVL_HI     = 14'h3800;
	localparam logic [WIN_BITS-1:0] CHAR_BYTES = 14'h0800;

	localparam logic [7:0] BANK0_RESET = 8'hC0;
	localparam logic [7:0] BANK1_RESET = 8'd33;
	localparam logic [7:0] BANK2_RESET = 8'd34;
	localparam logic [7:0] BANK3_RESET = 8'd19;

	// One translated access.
	typedef struct packed {
		target_t     target;
		logic [18:0] offset;
		logic        write_enable;
		logic [7:0]  store_byte;
		logic [7:0]  fill_byte;
	} result_t;

endpackage

// ===== rtl/bmm_decode.sv =====
module bmm_decode import bmm_pkg::*; #(
	parameter int BOOT_ROM_BYTES = 8192,
	parameter int MAIN_RAM_PAGES = 32
) (
	input  logic [1:0]  action,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	input  logic [7:0]  bank0,
	input  logic [7:0]  bank1,
	input  logic [7:0]  bank2,
	input  logic [7:0]  bank3,
	input  logic        remap,
	input  logic        cart,
	output result_t     result
);

	logic [1:0]          win;
	logic [WIN_BITS-1:0] a;
	logic [7:0]          reg_sel;
	logic [PAGE_BITS-1:0] page;
	logic                ovl;
	logic                ro;
	logic                is_write;
	logic                rw_target;
	logic                blocked;
	logic [7:0]          rfill;
	target_t             tgt;
	logic [18:0]         offs;

	assign a        = address[WIN_BITS-1:0];
	assign is_write = (action == ACT_WRITE);

	// Window select, with windows 0 and 3 traded when remap is on.
	always_comb begin
		win = address[15:14];
		if (remap && (win == 2'd0 || win == 2'd3)) begin
			win = win ^ 2'd3;
		end
		case (win)
			2'd0:    reg_sel = bank0;
			2'd1:    reg_sel = bank1;
			2'd2:    reg_sel = bank2;
			default: reg_sel = bank3;
		endcase
	end

	assign page = reg_sel[PAGE_BITS-1:0];
	assign ovl  = reg_sel[6];
	assign ro   = reg_sel[7];

	// Page decode into target and offset.
	always_comb begin
		tgt       = TGT_NONE;
		offs      = '0;
		rw_target = 1'b0;
		rfill     = 8'hFF;
		if (page == PAGE_BOOT) begin
			if ({1'b0, a} < 15'(BOOT_ROM_BYTES)) begin
				tgt  = TGT_BOOT;
				offs = 19'(a);
			end else begin
				rfill = 8'h00;
			end
		end else if (page == PAGE_CART) begin
			if (cart) begin
				tgt  = TGT_CART;
				offs = 19'(a);
			end
		end else if (page == PAGE_VRAM) begin
			tgt       = TGT_VRAM;
			offs      = 19'(a);
			rw_target = 1'b1;
		end else if (page == PAGE_CHRAM) begin
			if (a < CHAR_BYTES) begin
				tgt       = TGT_CHRAM;
				offs      = 19'(a);
				rw_target = 1'b1;
			end
		end else if (page[5] && ({1'b0, page[4:0]} < 6'(MAIN_RAM_PAGES))) begin
			// Main RAM page n+32 starts at n times 16K.
			tgt       = TGT_MAIN;
			offs      = {page[4:0], a};
			rw_target = 1'b1;
		end
	end

	assign blocked = ro && !(ovl && a >= OVL_HI);

	// Final result, with the overlay window taking precedence.
	always_comb begin
		result = '0;
		result.target = TGT_NONE;
		if (action == ACT_READ || action == ACT_WRITE) begin
			if (ovl && a >= OVL_LO && a < OVL_HI) begin
				result.target       = TGT_OVERLAY;
				result.offset       = 19'(a - OVL_LO);
				result.write_enable = is_write;
			end else begin
				result.target       = tgt;
				result.offset       = offs;
				result.write_enable = is_write && rw_target && !blocked;
				if (!is_write && tgt == TGT_NONE) begin
					result.fill_byte = rfill;
				end
			end
			if (result.write_enable) begin
				result.store_byte = data;
			end
		end
	end

endmodule

// ===== rtl/bmm_skid.sv =====
module bmm_skid import bmm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  result_t result,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_item
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Occupancy of the output register and the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves; no reset needed.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= result;
			end
		end else if (accept) begin
			skid_q <= result;
		end
	end

endmodule

// ===== rtl/banked_memory_mapper.sv =====
// Channel | Direction | Handshake            | Payload
// config  | in        | cfg_valid/cfg_ready  | cartridge_present
// access  | in        | in_valid/in_stall    | action, address, data
// result  | out       | out_valid/out_stall  | target, offset, write_enable,
//         |           |                      | store_byte, fill_byte
//
// One item is accepted per cycle while in_stall is low; its result is registered.
// Bank and remap writes take effect for the item that follows them.
// Reset loads the bank registers with C0h, 33, 34, 19 and clears remap.
// A two-entry output buffer absorbs one stalled result; in_stall is
// raised from a register only when both entries hold items.
module banked_memory_mapper import bmm_pkg::*; #(
	parameter int BOOT_ROM_BYTES = 8192,
	parameter int MAIN_RAM_PAGES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cartridge_present,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  target,
	output logic [18:0] offset,
	output logic        write_enable,
	output logic [7:0]  store_byte,
	output logic [7:0]  fill_byte
);

	logic [7:0] bank_q [4];
	logic       remap_q;
	logic       cart_q;
	logic       full;
	logic       accept;
	result_t    result;
	result_t    out_item;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !full;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_q <= 1'b0;
		end else if (cfg_valid) begin
			cart_q <= cartridge_present;
		end
	end

	// Bank registers and remap bit, written by register actions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q[0] <= BANK0_RESET;
			bank_q[1] <= BANK1_RESET;
			bank_q[2] <= BANK2_RESET;
			bank_q[3] <= BANK3_RESET;
			remap_q   <= 1'b0;
		end else if (accept) begin
			if (action == ACT_BANK_WR) begin
				bank_q[address[1:0]] <= data;
			end else if (action == ACT_REMAP_WR) begin
				remap_q <= data[0];
			end
		end
	end

	bmm_decode #(
		.BOOT_ROM_BYTES(BOOT_ROM_BYTES),
		.MAIN_RAM_PAGES(MAIN_RAM_PAGES)
	) u_decode (
		.action  (action),
		.address (address),
		.data    (data),
		.bank0   (bank_q[0]),
		.bank1   (bank_q[1]),
		.bank2   (bank_q[2]),
		.bank3   (bank_q[3]),
		.remap   (remap_q),
		.cart    (cart_q),
		.result  (result)
	);

	bmm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.result    (result),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	assign target       = out_item.target;
	assign offset       = out_item.offset;
	assign write_enable = out_item.write_enable;
	assign store_byte   = out_item.store_byte;
	assign fill_byte    = out_item.fill_byte;

endmodule
